// ===== hw/rtl/gpc_pkg.sv =====
// Shared types, register codes and helpers of the glyph pixel colourizer.
package gpc_pkg;

	// Row count at and above which the strike and underline rows saturate
	localparam int MAX_GLYPH_ROWS = 256;

	// Configuration register indexes
	localparam int          CFG_IDX_W   = 3;
	localparam logic [2:0]  REG_FORE    = 3'd0;
	localparam logic [2:0]  REG_BACK    = 3'd1;
	localparam logic [2:0]  REG_LEVEL   = 3'd2;
	localparam logic [2:0]  REG_FORMAT  = 3'd3;
	localparam logic [2:0]  REG_STYLE   = 3'd4;
	localparam logic [2:0]  REG_ROWS    = 3'd5;

	// Sample formats; anything above FMT_BGRA gives a black pixel off the line rows
	localparam logic [2:0]  FMT_MONO    = 3'd0;
	localparam logic [2:0]  FMT_GRAY    = 3'd1;
	localparam logic [2:0]  FMT_LCD     = 3'd2;
	localparam logic [2:0]  FMT_BGRA    = 3'd3;

	// Intensity levels; the unused code behaves as normal
	localparam logic [1:0]  LVL_NORMAL  = 2'd0;
	localparam logic [1:0]  LVL_DIM     = 2'd1;
	localparam logic [1:0]  LVL_BOLD    = 2'd2;

	// Style flag bit positions
	localparam int          STY_INVERT  = 0;
	localparam int          STY_UNDER   = 1;
	localparam int          STY_STRIKE  = 2;
	localparam int          STY_COLOUR  = 3;

	// Reset values of the registers
	localparam logic [23:0] FORE_RST    = 24'hFFFFFF;
	localparam logic [23:0] BACK_RST    = 24'h000000;
	localparam logic [7:0]  ROWS_RST    = 8'd16;

	typedef struct packed {
		logic [7:0] row_index;
		logic [7:0] sample_a;
		logic [7:0] sample_b;
		logic [7:0] sample_c;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pix_out_t;

	// Register file contents as seen by the pipeline
	typedef struct packed {
		logic [23:0] fore_color;
		logic [23:0] back_color;
		logic [1:0]  intensity_level;
		logic [2:0]  sample_format;
		logic [3:0]  style_flags;
		logic [7:0]  glyph_rows;
	} cfg_t;

	// Load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Scaled coverage and row overrides handed from coverage to blend
	typedef struct packed {
		logic [7:0] v_r;
		logic [7:0] v_g;
		logic [7:0] v_b;
		logic       strike_hit;
		logic       under_hit;
	} cov_t;

	// Intensity multiplier of a level code
	function automatic logic [7:0] level_max(input logic [1:0] lvl);
		logic [7:0] m;
		case (lvl)
			LVL_DIM:  m = 8'd145;
			LVL_BOLD: m = 8'd255;
			default:  m = 8'd200;
		endcase
		return m;
	endfunction

	// Exact p / 255 for any p up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ===== hw/rtl/gpc_cover.sv =====
// Coverage stages: sample selection, intensity scaling, divide by 255 and invert.
module gpc_cover (
	input  logic               clk,
	input  gpc_pkg::stage_en_t en,
	input  gpc_pkg::cfg_t      cfg,
	input  gpc_pkg::pix_in_t   pix,
	output gpc_pkg::cov_t      cov
);
	import gpc_pkg::*;

	logic [7:0]  m;
	logic        inv;
	logic [7:0]  rows_sat;
	logic [7:0]  s_r, s_g, s_b;
	logic [7:0]  ink;
	logic        strike_hit, under_hit;
	logic [7:0]  q_r, q_g, q_b;

	logic [15:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic        strike_s1, under_s1;
	cov_t        cov_s2;

	assign m   = level_max(cfg.intensity_level);
	assign inv = cfg.style_flags[STY_INVERT];
	assign ink = pix.sample_a[7] ? 8'hFF : 8'h00;

	// Pick the per-channel coverage bytes; non-colour subpixel modes use red only
	always_comb begin
		s_r = pix.sample_a;
		s_g = pix.sample_a;
		s_b = pix.sample_a;
		case (cfg.sample_format)
			FMT_MONO: begin
				s_r = ink;
				s_g = ink;
				s_b = ink;
			end
			FMT_LCD: begin
				s_r = pix.sample_a;
				s_g = cfg.style_flags[STY_COLOUR] ? pix.sample_b : pix.sample_a;
				s_b = cfg.style_flags[STY_COLOUR] ? pix.sample_c : pix.sample_a;
			end
			FMT_BGRA: begin
				s_r = pix.sample_c;
				s_g = cfg.style_flags[STY_COLOUR] ? pix.sample_b : pix.sample_c;
				s_b = cfg.style_flags[STY_COLOUR] ? pix.sample_a : pix.sample_c;
			end
			default: begin
				s_r = pix.sample_a;
				s_g = pix.sample_a;
				s_b = pix.sample_a;
			end
		endcase
	end

	// Strike and underline row matches
	always_comb begin
		if (int'(cfg.glyph_rows) >= MAX_GLYPH_ROWS)
			rows_sat = 8'(MAX_GLYPH_ROWS - 1);
		else
			rows_sat = cfg.glyph_rows;
		strike_hit = cfg.style_flags[STY_STRIKE] && (pix.row_index == (rows_sat >> 1));
		under_hit  = cfg.style_flags[STY_UNDER] && (rows_sat >= 8'd2) &&
		             (pix.row_index == rows_sat - 8'd2);
	end

	// Stage 1: coverage times multiplier
	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_r_s1 <= 16'(s_r) * 16'(m);
			prod_g_s1 <= 16'(s_g) * 16'(m);
			prod_b_s1 <= 16'(s_b) * 16'(m);
			strike_s1 <= strike_hit;
			under_s1  <= under_hit;
		end
	end

	assign q_r = div255(prod_r_s1);
	assign q_g = div255(prod_g_s1);
	assign q_b = div255(prod_b_s1);

	// Stage 2: divide by 255, optional inversion
	always_ff @(posedge clk) begin
		if (en.s2) begin
			cov_s2.v_r        <= inv ? m - q_r : q_r;
			cov_s2.v_g        <= inv ? m - q_g : q_g;
			cov_s2.v_b        <= inv ? m - q_b : q_b;
			cov_s2.strike_hit <= strike_s1;
			cov_s2.under_hit  <= under_s1;
		end
	end

	assign cov = cov_s2;

endmodule

// ===== hw/rtl/gpc_blend.sv =====
// Blend stages: colour products, then sum, pass-through and line overrides.
module gpc_blend (
	input  logic               clk,
	input  gpc_pkg::stage_en_t en,
	input  gpc_pkg::cfg_t      cfg,
	input  gpc_pkg::cov_t      cov,
	output gpc_pkg::pix_out_t  pix
);
	import gpc_pkg::*;

	logic [7:0]  m;
	logic [7:0]  line_v;
	logic        pass;
	logic        blank;
	logic [7:0]  fg_r, fg_g, fg_b, bg_r, bg_g, bg_b;
	logic [15:0] sum_r, sum_g, sum_b;

	logic [15:0] fp_r_s3, fp_g_s3, fp_b_s3;
	logic [15:0] bp_r_s3, bp_g_s3, bp_b_s3;
	logic [15:0] lp_r_s3, lp_g_s3, lp_b_s3;
	logic [7:0]  v_r_s3, v_g_s3, v_b_s3;
	logic        line_s3;
	pix_out_t    pix_s4;

	assign m    = level_max(cfg.intensity_level);
	assign fg_r = cfg.fore_color[23:16];
	assign fg_g = cfg.fore_color[15:8];
	assign fg_b = cfg.fore_color[7:0];
	assign bg_r = cfg.back_color[23:16];
	assign bg_g = cfg.back_color[15:8];
	assign bg_b = cfg.back_color[7:0];

	// Underline wins over strike; inverted underline is black
	assign line_v = (cov.under_hit && cfg.style_flags[STY_INVERT]) ? 8'd0 : m;

	// Stage 3: foreground, background and line products
	always_ff @(posedge clk) begin
		if (en.s3) begin
			fp_r_s3 <= 16'(cov.v_r) * 16'(fg_r);
			fp_g_s3 <= 16'(cov.v_g) * 16'(fg_g);
			fp_b_s3 <= 16'(cov.v_b) * 16'(fg_b);
			bp_r_s3 <= 16'(m - cov.v_r) * 16'(bg_r);
			bp_g_s3 <= 16'(m - cov.v_g) * 16'(bg_g);
			bp_b_s3 <= 16'(m - cov.v_b) * 16'(bg_b);
			lp_r_s3 <= 16'(line_v) * 16'(fg_r);
			lp_g_s3 <= 16'(line_v) * 16'(fg_g);
			lp_b_s3 <= 16'(line_v) * 16'(fg_b);
			v_r_s3  <= cov.v_r;
			v_g_s3  <= cov.v_g;
			v_b_s3  <= cov.v_b;
			line_s3 <= cov.strike_hit || cov.under_hit;
		end
	end

	assign pass  = cfg.style_flags[STY_COLOUR] &&
	               ((cfg.sample_format == FMT_LCD) || (cfg.sample_format == FMT_BGRA));
	assign blank = cfg.sample_format > FMT_BGRA;
	assign sum_r = fp_r_s3 + bp_r_s3;
	assign sum_g = fp_g_s3 + bp_g_s3;
	assign sum_b = fp_b_s3 + bp_b_s3;

	// Stage 4: output register
	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (line_s3) begin
				pix_s4.out_red   <= lp_r_s3[15:8];
				pix_s4.out_green <= lp_g_s3[15:8];
				pix_s4.out_blue  <= lp_b_s3[15:8];
			end else if (blank) begin
				pix_s4 <= '0;
			end else if (pass) begin
				pix_s4.out_red   <= v_r_s3;
				pix_s4.out_green <= v_g_s3;
				pix_s4.out_blue  <= v_b_s3;
			end else begin
				pix_s4.out_red   <= sum_r[15:8];
				pix_s4.out_green <= sum_g[15:8];
				pix_s4.out_blue  <= sum_b[15:8];
			end
		end
	end

	assign pix = pix_s4;

endmodule

// ===== hw/rtl/glyph_pixel_colorizer.sv =====
// Top level of the glyph pixel colourizer: register file, stage control, pipeline.
//
// Colours one glyph pixel per transfer through a four-stage pipeline: coverage times
// intensity, divide by 255 and invert, colour products, then sum and line override.
// One pixel can enter per clock unless all stages are full and the output stalls.
// Its colour is registered in stage 1 through stage 4 and presented from the stage 4
// register. A stall on the output holds only the stages that are occupied, so
// bubbles close up and the input keeps flowing until all four stages are full. The
// configuration port is always ready; write it only while the pipeline is empty.
module glyph_pixel_colorizer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gpc_pkg::pix_in_t     in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gpc_pkg::pix_out_t    out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import gpc_pkg::*;

	logic [23:0] fore_q, back_q;
	logic [1:0]  level_q;
	logic [2:0]  format_q;
	logic [3:0]  style_q;
	logic [7:0]  rows_q;
	cfg_t        cfg;
	stage_en_t   en;
	cov_t        cov;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q   <= FORE_RST;
			back_q   <= BACK_RST;
			level_q  <= LVL_NORMAL;
			format_q <= FMT_GRAY;
			style_q  <= 4'd0;
			rows_q   <= ROWS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FORE:   fore_q   <= cfg_data;
				REG_BACK:   back_q   <= cfg_data;
				REG_LEVEL:  level_q  <= cfg_data[1:0];
				REG_FORMAT: format_q <= cfg_data[2:0];
				REG_STYLE:  style_q  <= cfg_data[3:0];
				REG_ROWS:   rows_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.fore_color      = fore_q;
	assign cfg.back_color      = back_q;
	assign cfg.intensity_level = level_q;
	assign cfg.sample_format   = format_q;
	assign cfg.style_flags     = style_q;
	assign cfg.glyph_rows      = rows_q;

	// A stage loads when it is empty or its successor moves on
	assign en.s4 = !vld_s4 || !out_stall;
	assign en.s3 = !vld_s3 || en.s4;
	assign en.s2 = !vld_s2 || en.s3;
	assign en.s1 = !vld_s1 || en.s2;
	assign in_stall  = !en.s1;
	assign out_valid = vld_s4;

	// Valid bits travelling with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= in_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
		end
	end

	gpc_cover u_cover (
		.clk (clk),
		.en  (en),
		.cfg (cfg),
		.pix (in_data),
		.cov (cov)
	);

	gpc_blend u_blend (
		.clk (clk),
		.en  (en),
		.cfg (cfg),
		.cov (cov),
		.pix (out_data)
	);

`ifndef NO_ASSERTIONS
	// A free output never back-pressures the input
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// A full, stalled pipeline must refuse input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_stall) |-> in_stall)
		else $error("input taken into a full stalled pipeline");

	// An accepted pixel occupies the first stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("accepted pixel lost at stage one");

	// A delivered result with nothing behind it empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !vld_s3) |=> !out_valid)
		else $error("result repeated after transfer");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the glyph pixel colourizer with its own colour predictor.
`timescale 1ns / 1ps

module tb;
	import gpc_pkg::*;

	localparam int HANG_LIMIT = 2000;
	localparam int MAX_SHOWN  = 10;
	localparam logic [3:0] F_INV    = 4'(1 << STY_INVERT);
	localparam logic [3:0] F_UNDER  = 4'(1 << STY_UNDER);
	localparam logic [3:0] F_STRIKE = 4'(1 << STY_STRIKE);
	localparam logic [3:0] F_COLOUR = 4'(1 << STY_COLOUR);
	localparam logic [2:0] FMT_ODD_LO = 3'd4;
	localparam logic [2:0] FMT_ODD_HI = 3'd7;
	localparam logic [1:0] LVL_SPARE  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	pix_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	pix_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	// Predictor copy of the register file
	logic [23:0] fg_colour;
	logic [23:0] bg_colour;
	logic [1:0]  level_code;
	logic [2:0]  fmt_code;
	logic [3:0]  style_bits;
	logic [7:0]  row_count;

	// Ring of expected colours; write and read counts wrap through 16 entries
	pix_out_t pending_colours[16];
	int       pend_wr;
	int       pend_rd;
	int       pixels_sent;
	int       colours_checked;
	int       settings_used;
	int       mismatches;
	bit       quiet_tail;

	glyph_pixel_colorizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// Scaled, optionally inverted coverage of one sample byte
	function automatic logic [7:0] scaled_cov(input logic [7:0] s, input logic [7:0] m,
			input logic inv);
		logic [15:0] p;
		logic [7:0]  v;
		p = s * m;
		v = 8'(p / 16'd255);
		return inv ? m - v : v;
	endfunction

	// Blend of one channel; with m equal to v this is the solid line colour
	function automatic logic [7:0] tone(input logic [7:0] v, input logic [7:0] m,
			input logic [7:0] f, input logic [7:0] b);
		logic [16:0] acc;
		acc = v * f + (m - v) * b;
		return acc[15:8];
	endfunction

	function automatic pix_out_t mix(input logic [7:0] v, input logic [7:0] m);
		pix_out_t res;
		res.out_red   = tone(v, m, fg_colour[23:16], bg_colour[23:16]);
		res.out_green = tone(v, m, fg_colour[15:8], bg_colour[15:8]);
		res.out_blue  = tone(v, m, fg_colour[7:0], bg_colour[7:0]);
		return res;
	endfunction

	function automatic pix_out_t colour_pixel(input pix_in_t px);
		logic [7:0] m;
		logic [7:0] vr;
		logic [7:0] vg;
		logic [7:0] vb;
		logic       inv;
		pix_out_t   res;
		inv = style_bits[STY_INVERT];
		case (level_code)
			LVL_DIM:  m = 8'd145;
			LVL_BOLD: m = 8'd255;
			default:  m = 8'd200;
		endcase
		case (fmt_code)
			FMT_MONO: begin
				vr = px.sample_a[7] ? m : 8'd0;
				if (inv)
					vr = m - vr;
				res = mix(vr, m);
			end
			FMT_GRAY: res = mix(scaled_cov(px.sample_a, m, inv), m);
			FMT_LCD, FMT_BGRA: begin
				vr = scaled_cov(fmt_code == FMT_LCD ? px.sample_a : px.sample_c, m, inv);
				vg = scaled_cov(px.sample_b, m, inv);
				vb = scaled_cov(fmt_code == FMT_LCD ? px.sample_c : px.sample_a, m, inv);
				if (style_bits[STY_COLOUR])
					res = '{out_red: vr, out_green: vg, out_blue: vb};
				else
					res = mix(vr, m);
			end
			default: res = '0;
		endcase
		// strike line, then underline which takes precedence
		if (style_bits[STY_STRIKE] && px.row_index == (row_count >> 1))
			res = mix(m, m);
		if (style_bits[STY_UNDER] && row_count >= 8'd2 && px.row_index == row_count - 8'd2)
			res = mix(inv ? 8'd0 : m, inv ? 8'd0 : m);
		return res;
	endfunction

	// ---------------------------------------------------------------- drivers

	// One pixel transfer; valid stays high on return so the next pixel can follow
	task automatic send_pixel(input logic [7:0] row, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c);
		pix_in_t px;
		px = '{row_index: row, sample_a: a, sample_b: b, sample_c: c};
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_colours[4'(pend_wr)] = colour_pixel(px);
		pend_wr++;
		pixels_sent++;
	endtask

	// Stop sending and wait for every outstanding colour
	task automatic drain();
		in_valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FORE:   fg_colour  = val;
			REG_BACK:   bg_colour  = val;
			REG_LEVEL:  level_code = val[1:0];
			REG_FORMAT: fmt_code   = val[2:0];
			REG_STYLE:  style_bits = val[3:0];
			REG_ROWS:   row_count  = val[7:0];
			default: ;
		endcase
	endtask

	// Full register setting; only called with the pipeline empty
	task automatic configure(input logic [23:0] fg, input logic [23:0] bg,
			input logic [1:0] lvl, input logic [2:0] fmt, input logic [3:0] sty,
			input logic [7:0] rows);
		write_reg(REG_FORE, fg);
		write_reg(REG_BACK, bg);
		write_reg(REG_LEVEL, 24'(lvl));
		write_reg(REG_FORMAT, 24'(fmt));
		write_reg(REG_STYLE, 24'(sty));
		write_reg(REG_ROWS, 24'(rows));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [23:0] pick_colour();
		case ($urandom_range(0, 7))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			default: return 24'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	// Random setting biased towards the line rows and format edges
	task automatic random_setup();
		logic [7:0] rows;
		logic [2:0] fmt;
		int         r;
		r = $urandom_range(0, 9);
		case (r)
			0:       rows = 8'd0;
			1:       rows = 8'd1;
			2:       rows = 8'd2;
			3:       rows = 8'd255;
			4, 5:    rows = 8'($urandom_range(3, 20));
			default: rows = 8'($urandom_range(0, 255));
		endcase
		r = $urandom_range(0, 9);
		fmt = (r < 8) ? 3'(r % 4) : 3'($urandom_range(FMT_ODD_LO, FMT_ODD_HI));
		configure(pick_colour(), pick_colour(), 2'($urandom_range(0, 3)), fmt,
			4'($urandom_range(0, 15)), rows);
	endtask

	// Random pixel, often on the strike or underline row
	task automatic random_pixel();
		logic [7:0] row;
		case ($urandom_range(0, 7))
			0, 1:    row = row_count >> 1;
			2, 3:    row = row_count - 8'd2;
			default: row = 8'($urandom_range(0, 255));
		endcase
		send_pixel(row, pick_byte(), pick_byte(), pick_byte());
	endtask

	// ---------------------------------------------------------------- tests

	// Register values straight after reset: gray, normal, white on black
	task automatic test_reset_state();
		send_pixel(8'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(8'd15, 8'hFF, 8'h00, 8'h00);
		send_pixel(8'd8, 8'h80, 8'hFF, 8'hFF);
		drain();
	endtask

	task automatic test_mono_gray();
		configure(24'hFF8001, 24'h00FF7E, LVL_BOLD, FMT_MONO, 4'h0, 8'd16);
		send_pixel(8'd0, 8'h80, 8'h00, 8'h00);
		send_pixel(8'd1, 8'h7F, 8'hFF, 8'hFF);
		drain();
		configure(24'hFF8001, 24'h00FF7E, LVL_DIM, FMT_MONO, F_INV, 8'd16);
		send_pixel(8'd2, 8'hFF, 8'h00, 8'h00);
		send_pixel(8'd3, 8'h00, 8'h00, 8'h00);
		drain();
		configure(24'h123456, 24'hFEDCBA, LVL_NORMAL, FMT_GRAY, F_INV, 8'd16);
		send_pixel(8'd4, 8'hFF, 8'h00, 8'h00);
		send_pixel(8'd5, 8'h01, 8'h00, 8'h00);
		drain();
	endtask

	// LCD and BGRA with and without the colour font flag; spare level code
	task automatic test_subpixel();
		configure(24'hFFFFFF, 24'h000000, LVL_SPARE, FMT_LCD, 4'h0, 8'd16);
		send_pixel(8'd1, 8'h10, 8'hEE, 8'hFF);
		drain();
		configure(24'h000000, 24'hFFFFFF, LVL_BOLD, FMT_LCD, F_COLOUR, 8'd16);
		send_pixel(8'd2, 8'hFF, 8'h00, 8'h80);
		drain();
		configure(24'hA0B0C0, 24'h102030, LVL_DIM, FMT_BGRA, F_COLOUR | F_INV, 8'd16);
		send_pixel(8'd3, 8'h01, 8'hFE, 8'h7F);
		drain();
		configure(24'hA0B0C0, 24'h102030, LVL_NORMAL, FMT_BGRA, 4'h0, 8'd16);
		send_pixel(8'd4, 8'h33, 8'h44, 8'hCC);
		drain();
	endtask

	// Strike and underline rows, unknown formats, tiny and largest row counts
	task automatic test_line_rows();
		configure(24'hFF00FF, 24'h00FF00, LVL_NORMAL, FMT_ODD_HI, F_UNDER | F_STRIKE, 8'd10);
		send_pixel(8'd5, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'd8, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'd3, 8'hFF, 8'hFF, 8'hFF);
		drain();
		configure(24'hFFFFFF, 24'h000000, LVL_BOLD, FMT_ODD_LO,
			F_UNDER | F_STRIKE | F_INV, 8'd4);
		send_pixel(8'd2, 8'h80, 8'h80, 8'h80);
		drain();
		configure(24'h808080, 24'h0000FF, LVL_DIM, FMT_GRAY, F_UNDER | F_STRIKE, 8'd4);
		send_pixel(8'd2, 8'h00, 8'h00, 8'h00);
		drain();
		configure(24'hFFFFFF, 24'h202020, LVL_NORMAL, FMT_GRAY, F_UNDER | F_STRIKE, 8'd0);
		send_pixel(8'd0, 8'h40, 8'h00, 8'h00);
		drain();
		configure(24'hFFFFFF, 24'h202020, LVL_NORMAL, FMT_GRAY, F_UNDER | F_STRIKE, 8'd1);
		send_pixel(8'd0, 8'h40, 8'h00, 8'h00);
		drain();
		configure(24'h00FFFF, 24'hFF0000, LVL_BOLD, FMT_MONO, F_UNDER | F_STRIKE, 8'd255);
		send_pixel(8'd127, 8'h00, 8'h00, 8'h00);
		send_pixel(8'd253, 8'h00, 8'h00, 8'h00);
		send_pixel(8'd255, 8'h80, 8'h00, 8'h00);
		drain();
	endtask

	// Bulk of the run: random settings, each followed by a burst of pixels
	task automatic test_random_mix();
		int burst;
		while (pixels_sent < 900) begin
			random_setup();
			burst = $urandom_range(20, 80);
			repeat (burst) random_pixel();
			drain();
		end
	endtask

	// Closing stretch at full rate with no idling on either side
	task automatic test_full_rate();
		quiet_tail = 1'b1;
		repeat (3) begin
			random_setup();
			repeat (50) random_pixel();
			drain();
		end
	endtask

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			colours_checked++;
			if (pend_wr == pend_rd) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected colour %h at %0t", out_data, $realtime);
			end else begin
				want = pending_colours[4'(pend_rd)];
				pend_rd++;
				if (out_data.out_red !== want.out_red
						|| out_data.out_green !== want.out_green
						|| out_data.out_blue !== want.out_blue) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("colour mismatch at %0t: expected r%h g%h b%h, got r%h g%h b%h",
							$realtime, want.out_red, want.out_green, want.out_blue,
							out_data.out_red, out_data.out_green, out_data.out_blue);
				end
			end
		end
	end

	// Output back-pressure: bursts of stall mixed with quiet stretches
	initial begin
		forever begin
			if (quiet_tail || $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end else begin
				out_stall <= 1'($urandom_range(0, 1));
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run after too long without any transfer
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no transfer for %0d cycles", HANG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FORE;
		cfg_data  <= '0;
		quiet_tail      = 1'b0;
		pend_wr         = 0;
		pend_rd         = 0;
		pixels_sent     = 0;
		colours_checked = 0;
		settings_used   = 0;
		mismatches      = 0;
		fg_colour  = FORE_RST;
		bg_colour  = BACK_RST;
		level_code = LVL_NORMAL;
		fmt_code   = FMT_GRAY;
		style_bits = 4'h0;
		row_count  = ROWS_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_mono_gray();
		test_subpixel();
		test_line_rows();
		test_random_mix();
		test_full_rate();

		repeat (8) @(posedge clk);
		if (pend_wr != pend_rd)
			mismatches++;
		$display("%0d pixels over %0d register settings, %0d colours compared, %0d wrong",
			pixels_sent, settings_used, colours_checked, mismatches);
		$display("all formats, intensity codes and line rows run with stalls on both sides");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
